>>> hw/rtl/indexed_insert_erase_list_macros.svh
// Assertion macros used by the list datapath.
`ifndef INDEXED_INSERT_ERASE_LIST_MACROS_SVH
`define INDEXED_INSERT_ERASE_LIST_MACROS_SVH

// Same-cycle implication, checked on clk, off while arst_n is low.
`define IIEL_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off while arst_n is low.
`define IIEL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/iiel_pkg.sv
// Types, codes and defaults for the indexed insert/erase list.
package iiel_pkg;

	localparam int DEPTH_DEF  = 16;
	localparam int WORD_W_DEF = 32;

	localparam int FUNC_W  = 2;
	localparam int POS_W   = 4;
	localparam int FIELD_W = 32;
	localparam int COUNT_W = 5;
	localparam int STAT_W  = 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_APPEND = 2'd0,
		FN_INSERT = 2'd1,
		FN_READ   = 2'd2,
		FN_ERASE  = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_t;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [POS_W-1:0]   position;
		logic [FIELD_W-1:0] word_in;
	} req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] word_out;
		logic [COUNT_W-1:0] entry_count;
		logic [STAT_W-1:0]  status;
	} rsp_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_DECIDE,
		CS_MV_RD,
		CS_MV_WR,
		CS_FINISH
	} ctl_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic    latch;    // capture request beat
		logic    check;    // capture status code
		status_t status;
		logic    load_k;   // move index from count (insert) or position (erase)
		logic    rd_pos;   // read entry at position
		logic    mv_rd;    // read move source
		logic    mv_wr;    // write move destination, step index
		logic    put_word; // write request word (append at count, insert at position)
		logic    inc;
		logic    dec;
		logic    respond;
	} ctl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		func_t func;
		logic  bad_idx;
		logic  full;
		logic  more;       // another entry still has to move
	} dp_flags_t;

endpackage

>>> hw/rtl/iiel_ctl.sv
// Sequencing state machine for the indexed insert/erase list.
module iiel_ctl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  iiel_pkg::dp_flags_t flags,
	output logic                busy,
	output iiel_pkg::ctl_cmd_t  cmd
);
	import iiel_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;
	logic       move_ok;

	// insert or erase that passed its checks walks the store
	assign move_ok = ((flags.func == FN_INSERT) && !flags.bad_idx && !flags.full) ||
		((flags.func == FN_ERASE) && !flags.bad_idx);

	assign busy = (state_q != CS_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (start) state_d = CS_DECIDE;
			end
			CS_DECIDE: begin
				state_d = move_ok ? CS_MV_RD : CS_FINISH;
			end
			CS_MV_RD: begin
				state_d = flags.more ? CS_MV_WR : CS_FINISH;
			end
			CS_MV_WR: begin
				state_d = CS_MV_RD;
			end
			CS_FINISH: begin
				state_d = CS_IDLE;
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.status = ST_DONE;
		unique case (state_q)
			CS_IDLE: begin
				cmd.latch = start;
			end
			CS_DECIDE: begin
				cmd.check = 1'b1;
				unique case (flags.func)
					FN_APPEND: begin
						if (flags.full) begin
							cmd.status = ST_FULL;
						end else begin
							cmd.put_word = 1'b1;
							cmd.inc      = 1'b1;
						end
					end
					FN_INSERT: begin
						if (flags.bad_idx) begin
							cmd.status = ST_BAD_INDEX;
						end else if (flags.full) begin
							cmd.status = ST_FULL;
						end else begin
							cmd.load_k = 1'b1;
						end
					end
					FN_READ: begin
						if (flags.bad_idx) begin
							cmd.status = ST_BAD_INDEX;
						end else begin
							cmd.rd_pos = 1'b1;
						end
					end
					FN_ERASE: begin
						if (flags.bad_idx) begin
							cmd.status = ST_BAD_INDEX;
						end else begin
							cmd.load_k = 1'b1;
						end
					end
					default: begin
						cmd.status = ST_DONE;
					end
				endcase
			end
			CS_MV_RD: begin
				if (flags.more) begin
					cmd.mv_rd = 1'b1;
				end else if (flags.func == FN_INSERT) begin
					cmd.put_word = 1'b1;
					cmd.inc      = 1'b1;
				end else begin
					cmd.dec = 1'b1;
				end
			end
			CS_MV_WR: begin
				cmd.mv_wr = 1'b1;
			end
			CS_FINISH: begin
				cmd.respond = 1'b1;
			end
			default: begin
				cmd.latch = 1'b0;
			end
		endcase
	end

endmodule

>>> hw/rtl/iiel_dp.sv
// Datapath of the indexed insert/erase list: store, count, move index, result.
`include "indexed_insert_erase_list_macros.svh"

module iiel_dp #(
	parameter int DEPTH  = iiel_pkg::DEPTH_DEF,
	parameter int WORD_W = iiel_pkg::WORD_W_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  iiel_pkg::req_t      req,
	input  iiel_pkg::ctl_cmd_t  cmd,
	output iiel_pkg::dp_flags_t flags,
	output logic                done,
	output iiel_pkg::rsp_t      rsp
);
	import iiel_pkg::*;

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	req_t              req_q;
	status_t           st_q;
	logic [CNT_W-1:0]  used_q;
	logic [CNT_W-1:0]  k_q;
	logic [WORD_W-1:0] rdata_q;
	logic [WORD_W-1:0] mem [DEPTH];
	rsp_t              rsp_q;
	logic              done_q;

	logic [CNT_W-1:0]  pos_cnt;
	logic [CNT_W-1:0]  k_inc;
	logic [CNT_W-1:0]  k_dec;
	logic              is_ins;
	logic              we;
	logic [ADDR_W-1:0] wa;
	logic [WORD_W-1:0] wd;
	logic              re;
	logic [ADDR_W-1:0] ra;

	// position fits the count width once it has passed the index check
	assign pos_cnt = CNT_W'(req_q.position);
	assign k_inc   = k_q + 1'b1;
	assign k_dec   = k_q - 1'b1;
	assign is_ins  = (req_q.func == FN_INSERT);

	assign flags.func    = func_t'(req_q.func);
	assign flags.bad_idx = CMP_W'(req_q.position) >= CMP_W'(used_q);
	assign flags.full    = used_q >= CNT_W'(DEPTH);
	assign flags.more    = is_ins ? (k_q > pos_cnt) : (k_inc < used_q);

	// insert walks down from the count, erase walks up from the position
	always_comb begin
		we = cmd.put_word || cmd.mv_wr;
		if (cmd.mv_wr) begin
			wa = k_q[ADDR_W-1:0];
			wd = rdata_q;
		end else begin
			wa = (req_q.func == FN_APPEND) ? used_q[ADDR_W-1:0] : pos_cnt[ADDR_W-1:0];
			wd = WORD_W'(req_q.word_in);
		end
		re = cmd.rd_pos || cmd.mv_rd;
		if (cmd.mv_rd) begin
			ra = is_ins ? k_dec[ADDR_W-1:0] : k_inc[ADDR_W-1:0];
		end else begin
			ra = pos_cnt[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rdata_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) req_q <= req;
		if (cmd.check) st_q <= cmd.status;
		if (cmd.load_k) begin
			k_q <= is_ins ? used_q : pos_cnt;
		end else if (cmd.mv_wr) begin
			k_q <= is_ins ? k_dec : k_inc;
		end
		if (cmd.respond) begin
			rsp_q.word_out    <= ((req_q.func == FN_READ) && (st_q == ST_DONE)) ?
				FIELD_W'(rdata_q) : '0;
			rsp_q.entry_count <= COUNT_W'(used_q);
			rsp_q.status      <= st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.respond;
			if (cmd.inc) begin
				used_q <= used_q + 1'b1;
			end else if (cmd.dec) begin
				used_q <= used_q - 1'b1;
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`IIEL_ASSERT_IMPL(a_used_max, 1'b1, used_q <= CNT_W'(DEPTH), "count above depth")
	`IIEL_ASSERT_IMPL(a_inc_room, cmd.inc, used_q < CNT_W'(DEPTH), "count step on full store")
	`IIEL_ASSERT_IMPL(a_dec_room, cmd.dec, used_q != '0, "count drop on empty store")
	`IIEL_ASSERT_IMPL(a_mv_addr, cmd.mv_wr, k_q < CNT_W'(DEPTH), "move beyond store")
	`IIEL_ASSERT_NEXT(a_done_once, done_q, !done_q, "result strobe held two cycles")

endmodule

>>> hw/rtl/indexed_insert_erase_list.sv
// Top level of the indexed insert/erase list: controller plus datapath.
//
// Ordered list of up to DEPTH words of WORD_W bits. A request beat on req
// (func, position, word_in) is taken at a rising edge with start high and busy
// low. func: append, insert at index, read at index, erase at index.
// Every request yields exactly one result beat on rsp (word_out, entry_count,
// status), shown for a single cycle with done high. The receiver cannot stall;
// the result sits in its own register, so busy is already low while done is
// high and the next request may be taken in that cycle.
// Append, read and every refused request go from accept through decide to
// finish; insert and erase walk the store between decide and finish. The
// store is a single-port-write, registered-read memory, so each entry moved
// by insert or erase is read and then written, and the walk closes with the
// word write (insert) or count drop (erase). No request is taken while busy.
// Status reports a full store or an index not below the count; refused
// requests change nothing. Reset (arst_n low) empties the list at once; the
// store contents are left as they are and never read before being written.
module indexed_insert_erase_list #(
	parameter int DEPTH  = iiel_pkg::DEPTH_DEF,
	parameter int WORD_W = iiel_pkg::WORD_W_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  iiel_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output iiel_pkg::rsp_t rsp
);
	import iiel_pkg::*;

	ctl_cmd_t  cmd;
	dp_flags_t flags;

	// sequencer: decide, walk the store, finish
	iiel_ctl u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.busy   (busy),
		.cmd    (cmd)
	);

	// store, count and result register
	iiel_dp #(
		.DEPTH  (DEPTH),
		.WORD_W (WORD_W)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.flags  (flags),
		.done   (done),
		.rsp    (rsp)
	);

endmodule
